FILE: src/fpundo_pkg.sv
// Shared types and constants for the floating-point predictor undo block.
`default_nettype none
package fpundo_pkg;

    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_MAX_BPS     = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SAMPLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_LINE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_ENDIAN_ORDER = 2'd2;

    localparam logic [3:0]  RST_BYTES_PER_SAMPLE    = 4'd4;
    localparam logic [12:0] RST_SAMPLES_PER_LINE    = 13'd4096;
    localparam logic        RST_LITTLE_ENDIAN_ORDER = 1'b1;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_WORD_W = 64;
    localparam int OUT_IDX_W  = 12;
    localparam int OUT_DATA_W = 80;

    // Live configuration after range clamping.
    typedef struct packed {
        logic [3:0] bps;
        logic       little_endian;
    } t_cfg;

    // What travels with a byte of the last plane toward the output.
    typedef struct packed {
        logic [7:0]           sum;
        logic [OUT_IDX_W-1:0] index;
        logic                 last;
    } t_item;

endpackage
`default_nettype wire

FILE: src/float_predictor_undo.sv
// Top level of the floating-point predictor undo block.
// Takes one differenced byte per cycle unless the output side stalls, planes in
// order, most significant plane first, and emits one restored sample per byte
// of the last plane. The running sum is a single 8-bit add. Bytes of the earlier
// planes go into a row store (one row per sample, one byte lane per plane): each
// accepted byte writes one lane or, on the last plane, reads its row into a
// register, and the sample then moves on into the output register. The store
// needs no clearing pass: each row is written in the same line before it is
// read. Any configuration write restarts the line.
`default_nettype none
module float_predictor_undo #(
    parameter int MAX_SAMPLES = fpundo_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_BPS     = fpundo_pkg::DEF_MAX_BPS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fpundo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fpundo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // [7:0] diff_byte
    input  wire logic [fpundo_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [63:0] sample_bytes, [75:64] sample_index, [79:76] zero
    output      logic [fpundo_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output      logic                              m_axis_tlast
);
    import fpundo_pkg::*;

    localparam int LANES = (MAX_BPS > 1) ? MAX_BPS - 1 : 1;
    localparam int SW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int PW    = (MAX_BPS > 1) ? $clog2(MAX_BPS) : 1;

    logic                  accept;
    t_cfg                  cfg;
    t_item                 item;
    logic                  wr_en;
    logic                  rd_en;
    logic [PW-1:0]         plane;
    logic [SW-1:0]         addr;
    logic [LANES-1:0][7:0] row;
    logic [OUT_WORD_W-1:0] word;
    logic [OUT_IDX_W-1:0]  index;

    assign accept = s_axis_tvalid && s_axis_tready;

    fpundo_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_BPS     (MAX_BPS),
        .SW          (SW),
        .PW          (PW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .o_cfg       (cfg),
        .o_item      (item),
        .o_wr_en     (wr_en),
        .o_rd_en     (rd_en),
        .o_plane     (plane),
        .o_addr      (addr)
    );

    fpundo_row_store #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_BPS     (MAX_BPS),
        .LANES       (LANES),
        .SW          (SW),
        .PW          (PW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_lane (plane),
        .i_wr_data (item.sum),
        .i_rd_en   (rd_en),
        .i_addr    (addr),
        .o_rd_row  (row)
    );

    fpundo_pack #(
        .MAX_BPS (MAX_BPS),
        .LANES   (LANES)
    ) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (rd_en),
        .i_item      (item),
        .i_cfg       (cfg),
        .i_row       (row),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_word      (word),
        .o_index     (index),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, index, word};

endmodule
`default_nettype wire

FILE: src/fpundo_row_store.sv
// Row store: one row per sample holding the bytes of every plane but the last.
`default_nettype none
module fpundo_row_store #(
    parameter int MAX_SAMPLES = fpundo_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_BPS     = fpundo_pkg::DEF_MAX_BPS,
    parameter int LANES       = (MAX_BPS > 1) ? MAX_BPS - 1 : 1,
    parameter int SW          = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    parameter int PW          = (MAX_BPS > 1) ? $clog2(MAX_BPS) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [PW-1:0]         i_wr_lane,
    input  wire logic [7:0]            i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [SW-1:0]         i_addr,
    output      logic [LANES-1:0][7:0] o_rd_row
);
    import fpundo_pkg::*;

    logic [LANES-1:0][7:0] r_mem [MAX_SAMPLES];

    // Byte-wide write into one lane; the whole row is read for the last plane.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_wr_en && (i_wr_lane == PW'(l))) begin
                r_mem[i_addr][l] <= i_wr_data;
            end
        end
        if (i_rd_en) begin
            o_rd_row <= r_mem[i_addr];
        end
    end

endmodule
`default_nettype wire

FILE: src/fpundo_ctrl.sv
// Configuration registers, running byte sum and plane and sample counters.
`default_nettype none
module fpundo_ctrl #(
    parameter int MAX_SAMPLES = fpundo_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_BPS     = fpundo_pkg::DEF_MAX_BPS,
    parameter int SW          = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    parameter int PW          = (MAX_BPS > 1) ? $clog2(MAX_BPS) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fpundo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fpundo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                              i_accept,
    input  wire logic [7:0]                        i_byte,
    output      fpundo_pkg::t_cfg                  o_cfg,
    output      fpundo_pkg::t_item                 o_item,
    output      logic                              o_wr_en,
    output      logic                              o_rd_en,
    output      logic [PW-1:0]                     o_plane,
    output      logic [SW-1:0]                     o_addr
);
    import fpundo_pkg::*;

    localparam int SPLW = ($clog2(MAX_SAMPLES + 1) > 13) ? $clog2(MAX_SAMPLES + 1) : 13;

    logic [3:0]    r_bps;
    logic [12:0]   r_spl;
    logic          r_le;
    logic [7:0]    r_sum;
    logic [PW-1:0] r_plane;
    logic [SW-1:0] r_sample;

    logic [7:0]      n_sum;
    logic [PW-1:0]   n_plane;
    logic [SW-1:0]   n_sample;
    logic [3:0]      bps_eff;
    logic [SPLW-1:0] spl_eff;
    logic            final_plane;
    logic            last_sample;

    always_comb begin
        if (r_bps == 4'd0) begin
            bps_eff = 4'd1;
        end else if (r_bps > 4'(MAX_BPS)) begin
            bps_eff = 4'(MAX_BPS);
        end else begin
            bps_eff = r_bps;
        end
        if (r_spl == 13'd0) begin
            spl_eff = SPLW'(1);
        end else if (SPLW'(r_spl) > SPLW'(MAX_SAMPLES)) begin
            spl_eff = SPLW'(MAX_SAMPLES);
        end else begin
            spl_eff = SPLW'(r_spl);
        end
    end

    assign final_plane = (4'(r_plane) == bps_eff - 4'd1);
    assign last_sample = (SPLW'(r_sample) == spl_eff - SPLW'(1));

    always_comb begin
        n_sum    = r_sum + i_byte;
        n_plane  = r_plane;
        n_sample = r_sample;
        if (i_accept) begin
            if (!final_plane) begin
                if (last_sample) begin
                    n_sample = '0;
                    n_plane  = r_plane + PW'(1);
                end else begin
                    n_sample = r_sample + SW'(1);
                end
            end else if (last_sample) begin
                n_sample = '0;
                n_plane  = '0;
            end else begin
                n_sample = r_sample + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps    <= RST_BYTES_PER_SAMPLE;
            r_spl    <= RST_SAMPLES_PER_LINE;
            r_le     <= RST_LITTLE_ENDIAN_ORDER;
            r_sum    <= '0;
            r_plane  <= '0;
            r_sample <= '0;
        end else if (i_cfg_we) begin
            // Any write, also to an unused index, starts a fresh line.
            unique case (i_cfg_index)
                CFG_BYTES_PER_SAMPLE:    r_bps <= i_cfg_data[3:0];
                CFG_SAMPLES_PER_LINE:    r_spl <= i_cfg_data[12:0];
                CFG_LITTLE_ENDIAN_ORDER: r_le  <= i_cfg_data[0];
                default: ;
            endcase
            r_sum    <= '0;
            r_plane  <= '0;
            r_sample <= '0;
        end else if (i_accept) begin
            r_sum    <= (final_plane && last_sample) ? 8'd0 : n_sum;
            r_plane  <= n_plane;
            r_sample <= n_sample;
        end
    end

    assign o_cfg.bps           = bps_eff;
    assign o_cfg.little_endian = r_le;
    assign o_item.sum          = n_sum;
    assign o_item.index        = OUT_IDX_W'(r_sample);
    assign o_item.last         = last_sample;
    assign o_wr_en             = i_accept && !final_plane;
    assign o_rd_en             = i_accept && final_plane;
    assign o_plane             = r_plane;
    assign o_addr              = r_sample;

    a_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        4'(r_plane) < bps_eff)
        else $error("plane counter beyond the last plane");

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SPLW'(r_sample) < spl_eff)
        else $error("sample counter beyond the line length");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && final_plane && last_sample && !i_cfg_we)
        |=> (r_sum == 8'd0 && r_plane == '0 && r_sample == '0))
        else $error("line did not restart after its last sample");

    a_store_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("row store written and read by the same item");

endmodule
`default_nettype wire

FILE: src/fpundo_pack.sv
// Read-data stage, byte ordering of the sample and the output register.
`default_nettype none
module fpundo_pack #(
    parameter int MAX_BPS = fpundo_pkg::DEF_MAX_BPS,
    parameter int LANES   = (MAX_BPS > 1) ? MAX_BPS - 1 : 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_load,
    input  wire fpundo_pkg::t_item                  i_item,
    input  wire fpundo_pkg::t_cfg                   i_cfg,
    input  wire logic [LANES-1:0][7:0]              i_row,
    output      logic                               o_ready,
    output      logic                               o_valid,
    input  wire logic                               i_out_ready,
    output      logic [fpundo_pkg::OUT_WORD_W-1:0]  o_word,
    output      logic [fpundo_pkg::OUT_IDX_W-1:0]   o_index,
    output      logic                               o_last
);
    import fpundo_pkg::*;

    logic  r_s1_valid;
    t_item r_s1_item;
    logic  r_out_valid;
    logic  s1_move;
    logic [OUT_WORD_W-1:0] word;
    logic [3:0] plane;
    logic [7:0] v;

    assign s1_move = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_ready = !r_s1_valid || s1_move;

    // Memory byte b takes plane bps-1-b in little endian order, plane b otherwise.
    always_comb begin
        word  = '0;
        plane = '0;
        v     = '0;
        for (int b = 0; b < OUT_WORD_W / 8; b++) begin
            plane = i_cfg.little_endian ? (i_cfg.bps - 4'd1 - 4'(b)) : 4'(b);
            v     = 8'd0;
            if (plane == i_cfg.bps - 4'd1) begin
                v = r_s1_item.sum;
            end else begin
                for (int l = 0; l < LANES; l++) begin
                    if (plane == 4'(l)) begin
                        v = i_row[l];
                    end
                end
            end
            if (4'(b) < i_cfg.bps) begin
                word[8*b +: 8] = v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_item <= i_item;
        end
        if (s1_move) begin
            o_word  <= word;
            o_index <= r_s1_item.index;
            o_last  <= r_s1_item.last;
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: bench/sample_restore_checker.sv
`timescale 1ns / 100ps
// Checker that predicts restored samples from the accepted bytes and compares the output stream.
module sample_restore_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fpundo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpundo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    // [7:0] diff_byte
    input  logic [fpundo_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    // [63:0] sample_bytes, [75:64] sample_index, [79:76] zero
    input  logic [fpundo_pkg::OUT_DATA_W-1:0] i_out_data,
    input  logic                              i_out_last,
    output int                                o_mismatches,
    output int                                o_pending
);
    import fpundo_pkg::*;

    typedef struct packed {
        logic [OUT_WORD_W-1:0] bytes;
        logic [OUT_IDX_W-1:0]  index;
        logic                  last;
    } t_sample;

    t_sample     expected_samples[$];
    logic [7:0]  plane_bytes [0:DEF_MAX_BPS-1][0:DEF_MAX_SAMPLES-1];
    logic [3:0]  reg_bps;
    logic [12:0] reg_spl;
    logic        reg_le;
    logic [7:0]  run_sum;
    int unsigned plane_no;
    int unsigned sample_no;
    int          mism_count;

    function automatic int unsigned clamped_bps();
        if (reg_bps == 0) return 1;
        if (reg_bps > DEF_MAX_BPS) return DEF_MAX_BPS;
        return reg_bps;
    endfunction

    function automatic int unsigned clamped_spl();
        if (reg_spl == 0) return 1;
        if (reg_spl > DEF_MAX_SAMPLES) return DEF_MAX_SAMPLES;
        return reg_spl;
    endfunction

    task automatic restart_line();
        run_sum   = '0;
        plane_no  = 0;
        sample_no = 0;
    endtask

    // Adds one differenced byte to the running sum and queues a sample when
    // the byte belongs to the last plane.
    task automatic restore_byte(input logic [7:0] diff);
        int unsigned nbps;
        int unsigned nspl;
        int unsigned plane;
        logic [7:0]  lane;
        t_sample     s;
        nbps    = clamped_bps();
        nspl    = clamped_spl();
        run_sum = run_sum + diff;
        if (plane_no >= nbps) plane_no = nbps - 1;
        if (sample_no >= nspl) sample_no = 0;
        if (plane_no + 1 < nbps) begin
            plane_bytes[plane_no][sample_no] = run_sum;
            sample_no++;
            if (sample_no >= nspl) begin
                sample_no = 0;
                plane_no++;
            end
        end else begin
            s.bytes = '0;
            for (int b = 0; b < nbps; b++) begin
                plane = reg_le ? (nbps - 1 - b) : b;
                lane  = (plane == nbps - 1) ? run_sum : plane_bytes[plane][sample_no];
                s.bytes[8*b +: 8] = lane;
            end
            s.index = sample_no[OUT_IDX_W-1:0];
            s.last  = (sample_no + 1 >= nspl);
            expected_samples = {expected_samples, s};
            if (s.last) restart_line();
            else sample_no++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        mism_count++;
    endtask

    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            reg_bps    = RST_BYTES_PER_SAMPLE;
            reg_spl    = RST_SAMPLES_PER_LINE;
            reg_le     = RST_LITTLE_ENDIAN_ORDER;
            mism_count = 0;
            expected_samples.delete();
            restart_line();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BYTES_PER_SAMPLE:    reg_bps = i_cfg_data[3:0];
                    CFG_SAMPLES_PER_LINE:    reg_spl = i_cfg_data[12:0];
                    CFG_LITTLE_ENDIAN_ORDER: reg_le  = i_cfg_data[0];
                    default: ;
                endcase
                // Any write, even to an unused index, starts a fresh line.
                restart_line();
            end
            if (i_in_valid && i_in_ready) restore_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("sample with none expected", i_out_data[63:0], '0);
                end else begin
                    want = expected_samples.pop_front();
                    if (i_out_data[63:0] !== want.bytes)
                        report_mismatch("sample_bytes", i_out_data[63:0], want.bytes);
                    if (i_out_data[75:64] !== want.index)
                        report_mismatch("sample_index", 64'(i_out_data[75:64]),
                                        64'(want.index));
                    if (i_out_last !== want.last)
                        report_mismatch("last_in_line", 64'(i_out_last), 64'(want.last));
                    if (i_out_data[79:76] !== 4'd0)
                        report_mismatch("tdata padding", 64'(i_out_data[79:76]), '0);
                end
            end
        end
        o_pending    <= expected_samples.size();
        o_mismatches <= mism_count;
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top that feeds differenced byte lines to the block and reports the verdict.
module tb_top;
    import fpundo_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET   = 1000;
    localparam int LONG_CUT      = 256;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;
    int mismatches;
    int pending;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    float_predictor_undo DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sample_restore_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int line_bytes(input logic [3:0] bps, input logic [12:0] spl);
        int nbps;
        int nspl;
        nbps = (bps == 0) ? 1 : (bps > DEF_MAX_BPS) ? DEF_MAX_BPS : bps;
        nspl = (spl == 0) ? 1 : (spl > DEF_MAX_SAMPLES) ? DEF_MAX_SAMPLES : spl;
        return nbps * nspl;
    endfunction

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_TX:   begin tx_idle_pct = 50; rx_stall_pct = 0;  end
            IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 50; end
            default:   begin tx_idle_pct = 27; rx_stall_pct = 27; end
        endcase
    endtask

    // One write per call; the enable then goes low before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Unused upper data bits are filled at random; the block must ignore them.
    task automatic set_config(input logic [3:0] bps, input logic [12:0] spl,
                              input logic le);
        write_reg(CFG_BYTES_PER_SAMPLE, {9'($urandom), bps});
        write_reg(CFG_SAMPLES_PER_LINE, spl);
        write_reg(CFG_LITTLE_ENDIAN_ORDER, {12'($urandom), le});
    endtask

    task automatic send_byte(input logic [7:0] diff);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= diff;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
    endtask

    task automatic send_line(input int n);
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    // Leaves the block idle: every expected sample has come out and the
    // pipeline has had time to finish any byte that makes no sample.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [3:0]  bps;
        logic [12:0] spl;
        int          r;
        int          len;
        int          phase;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Two planes, little endian, with sums that wrap.
        set_config(4'd2, 13'd2, 1'b1);
        send_byte(8'h00); send_byte(8'hff); send_byte(8'h80); send_byte(8'h01);
        drain();
        // Same shape in big endian order.
        write_reg(CFG_LITTLE_ENDIAN_ORDER, 13'd0);
        send_byte(8'h7f); send_byte(8'h81); send_byte(8'hfe); send_byte(8'h02);
        drain();
        // Zero sizes act as one byte and one sample: every item ends a line.
        set_config(4'd0, 13'd0, 1'b1);
        send_byte(8'hff); send_byte(8'h01);
        drain();
        // Oversized sample acts as eight planes.
        set_config(4'd15, 13'd1, 1'b0);
        repeat (8) send_byte(8'($urandom_range(255)));
        drain();
        // A write to the unused index in the middle of a line restarts it.
        set_config(4'd3, 13'd2, 1'b1);
        send_byte(8'h55); send_byte(8'haa);
        drain();
        write_reg(CFG_SPARE_INDEX, 13'($urandom));
        send_line(6);
        drain();

        items_sent = 0;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            set_idle(t_idle_mode'(phase % 4));
            r = $urandom_range(9);
            bps = (r == 0) ? 4'($urandom_range(15, 9)) :
                  (r == 1) ? 4'd0 : 4'($urandom_range(DEF_MAX_BPS, 1));
            r = $urandom_range(9);
            spl = (r == 0) ? 13'd0 :
                  (r == 1) ? 13'($urandom_range(120, 25)) : 13'($urandom_range(24, 1));
            set_config(bps, spl, 1'($urandom));
            len = line_bytes(bps, spl);
            repeat ((len > 200) ? 1 : $urandom_range(3, 1)) send_line(len);
            // Now and then a line is cut short and restarted by a write.
            if ($urandom_range(4) == 0) begin
                send_line($urandom_range(len, 1));
                drain();
                write_reg(CFG_SPARE_INDEX, 13'($urandom));
                send_line(len);
            end
            drain();
            phase++;
        end

        // Longest lines, exactly the maximum and then a length beyond it; each
        // is cut short, and the first is restarted by the next configuration write.
        set_idle(IDLE_TX);
        set_config(4'd1, 13'd4096, 1'b0);
        send_line(LONG_CUT);
        drain();
        set_idle(IDLE_BOTH);
        set_config(4'd0, 13'h1fff, 1'b1);
        send_line(LONG_CUT);
        drain();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
